// ----- hw/rtl/nfba_pkg.sv -----
// Shared codes and types of the next-fit block allocator.
package nfba_pkg;

  typedef enum logic [1:0] {
    MODE_ALLOC  = 2'd0,
    MODE_FREE   = 2'd1,
    MODE_QUERY  = 2'd2,
    MODE_RELOAD = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_NODESC  = 2'd2,
    ST_BADADDR = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_POOL_START  = 2'd0,
    CFG_POOL_LENGTH = 2'd1,
    CFG_LINE_BYTES  = 2'd2
  } cfg_idx_e;

  localparam logic [31:0] QUERY_MASK    = 32'hFFFF_FFF0;
  localparam logic [31:0] QUERY_BIAS    = 32'd15;
  localparam logic [15:0] LINE_BYTES_RST = 16'd16;

  // Request to the size rounding unit.
  typedef struct packed {
    logic        start;
    logic [32:0] size;
    logic [15:0] gran;
  } rnd_req_t;

  // Answer of the size rounding unit.
  typedef struct packed {
    logic        done;
    logic [33:0] amt;
  } rnd_rsp_t;

endpackage

// ----- hw/rtl/nfba_if.sv -----
// Request and result channel interfaces of the allocator.
interface nfba_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [31:0] request_size;
  logic [31:0] block_address;

  modport source (output valid, output mode, output request_size, output block_address,
                  input ready);
  modport sink (input valid, input mode, input request_size, input block_address,
                output ready);
endinterface

interface nfba_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_value;
  logic [1:0]  status;

  modport source (output valid, output result_value, output status, input ready);
  modport sink (input valid, input result_value, input status, output ready);
endinterface

// ----- hw/rtl/nfba_desc_ram.sv -----
// Descriptor memory: one write port and one read port with registered read data.
module nfba_desc_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 73
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- hw/rtl/nfba_round.sv -----
// Rounds a request size up to a multiple of the line granule, one quotient bit a cycle.
module nfba_round import nfba_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  rnd_req_t req_i,
  output rnd_rsp_t rsp_o
);

  logic        busy_q, busy_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [32:0] sh_q, sh_d;
  logic [32:0] sz_q, sz_d;
  logic [15:0] g_q, g_d;
  logic [16:0] rem_q, rem_d;
  logic [16:0] rem_sh;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    sh_d   = sh_q;
    sz_d   = sz_q;
    g_d    = g_q;
    rem_d  = rem_q;
    rem_sh = {rem_q[15:0], sh_q[32]};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = 6'd33;
      sh_d   = req_i.size;
      sz_d   = req_i.size;
      g_d    = req_i.gran;
      rem_d  = '0;
    end else if (busy_q) begin
      if (cnt_q == 6'd0) begin
        busy_d = 1'b0;
      end else begin
        rem_d = (rem_sh >= {1'b0, g_q}) ? rem_sh - {1'b0, g_q} : rem_sh;
        sh_d  = {sh_q[31:0], 1'b0};
        cnt_d = cnt_q - 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    sz_q  <= sz_d;
    g_q   <= g_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = busy_q && (cnt_q == 6'd0);
  assign rsp_o.amt  = (rem_q == 17'd0) ? {1'b0, sz_q}
                    : {1'b0, sz_q} + {18'd0, g_q} - {17'd0, rem_q};

endmodule

// ----- hw/rtl/next_fit_block_allocator_unit.sv -----
// Top level of the next-fit block allocator with its list-walking sequencer.
// The allocator manages one memory region through a table of MAX_DESCRIPTORS block
// descriptors held in a synchronous memory. Free blocks are linked in address order,
// allocated blocks newest first, and a search pointer makes allocation next fit. One
// request beat is handled at a time and gives exactly one result beat. A reload
// writes descriptor 0 as the whole pool; a query walks the free list for the largest
// block. An allocation rounds the size to whole lines, reads the descriptor at the
// search pointer, then visits the free descriptors in turn, hunts for a spare
// descriptor when a block is split, and writes back and presents the result. A free
// examines allocated blocks up to and including the match, then free blocks while
// finding the place of insertion, then merges and writes back. The pace of each walk
// is set by the memory's single read port: each visited descriptor needs one read
// and the next address comes from its data. Writes and reads are issued in separate
// sequencer states, so no read can meet a write to the same entry and the memory
// needs no forwarding. The result beat sits in an output register, so the next
// request is taken while a result waits.
module next_fit_block_allocator_unit import nfba_pkg::*; #(
  parameter int MAX_DESCRIPTORS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  nfba_in_if.sink     in_s,
  nfba_out_if.source  out_m,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  localparam int IW = $clog2(MAX_DESCRIPTORS);
  localparam int NW = IW + 1;
  localparam logic [NW-1:0] NIL = NW'(MAX_DESCRIPTORS);
  localparam logic [IW-1:0] LAST = IW'(MAX_DESCRIPTORS - 1);

  typedef struct packed {
    logic [NW-1:0] nxt;
    logic [31:0]   len;
    logic [31:0]   start;
  } desc_t;

  localparam int DW = $bits(desc_t);

  typedef enum logic [21:0] {
    S_IDLE   = 22'b0000000000000000000001,
    S_DIV    = 22'b0000000000000000000010,
    S_A_SP   = 22'b0000000000000000000100,
    S_A_SPD  = 22'b0000000000000000001000,
    S_A_CHK  = 22'b0000000000000000010000,
    S_A_EVAL = 22'b0000000000000000100000,
    S_A_GRAB = 22'b0000000000000001000000,
    S_A_WS   = 22'b0000000000000010000000,
    S_A_WQ   = 22'b0000000000000100000000,
    S_A_WP   = 22'b0000000000001000000000,
    S_F_CHK  = 22'b0000000000010000000000,
    S_F_EVAL = 22'b0000000000100000000000,
    S_F_ICHK = 22'b0000000001000000000000,
    S_F_IEVL = 22'b0000000010000000000000,
    S_F_MN   = 22'b0000000100000000000000,
    S_F_MP   = 22'b0000001000000000000000,
    S_F_WM   = 22'b0000010000000000000000,
    S_F_WQ   = 22'b0000100000000000000000,
    S_Q_CHK  = 22'b0001000000000000000000,
    S_Q_EVAL = 22'b0010000000000000000000,
    S_DONE   = 22'b0100000000000000000000,
    S_SPARE  = 22'b1000000000000000000000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [31:0] pool_start_q, pool_length_q;
  logic [15:0] line_bytes_q;

  // List heads, search pointer and descriptor ownership bits.
  logic [NW-1:0] free_head_q, free_head_d;
  logic [NW-1:0] used_head_q, used_head_d;
  logic [NW-1:0] sp_q, sp_d;
  logic [MAX_DESCRIPTORS-1:0] in_use_q, in_use_d;

  // Walk registers: p is the visited descriptor, q the one before it, m the
  // block being freed and s the spare taken for a split.
  logic [NW-1:0] p_q, p_d, q_q, q_d, m_q, m_d, s_q, s_d, link_q, link_d;
  desc_t         ep_q, ep_d, eq_q, eq_d, em_q, em_d;
  logic [IW-1:0] gi_q, gi_d;
  logic [31:0]   amt_q, amt_d;
  logic [31:0]   addr_q, addr_d;
  logic [31:0]   best_q, best_d;
  logic [31:0]   res_q, res_d;
  status_e       st_q, st_d;

  // Output register.
  logic        out_valid_q;
  logic [31:0] out_res_q;
  status_e     out_st_q;
  logic        load;

  // Memory and rounding unit hookup.
  logic          ram_we;
  logic [IW-1:0] ram_waddr, ram_raddr;
  desc_t         ram_wdata;
  logic [DW-1:0] ram_rdata;
  desc_t         rd;
  rnd_req_t      rnd_req;
  rnd_rsp_t      rnd_rsp;

  function automatic logic vld(input logic [NW-1:0] d);
    return d < NIL;
  endfunction

  assign rd = desc_t'(ram_rdata);

  nfba_desc_ram #(
    .DEPTH (MAX_DESCRIPTORS),
    .AW    (IW),
    .DW    (DW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  nfba_round u_round (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rnd_req),
    .rsp_o  (rnd_rsp)
  );

  assign in_s.ready = (state_q == S_IDLE);
  assign load = (state_q == S_DONE) && (!out_valid_q || out_m.ready);

  always_comb begin
    desc_t         em_n;
    desc_t         eq_n;
    logic [NW-1:0] sp1;
    state_d     = state_q;
    free_head_d = free_head_q;
    used_head_d = used_head_q;
    sp_d        = sp_q;
    in_use_d    = in_use_q;
    p_d         = p_q;
    q_d         = q_q;
    m_d         = m_q;
    s_d         = s_q;
    link_d      = link_q;
    ep_d        = ep_q;
    eq_d        = eq_q;
    em_d        = em_q;
    gi_d        = gi_q;
    amt_d       = amt_q;
    addr_d      = addr_q;
    best_d      = best_q;
    res_d       = res_q;
    st_d        = st_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_raddr   = '0;
    rnd_req     = '0;
    em_n        = em_q;
    eq_n        = eq_q;
    sp1         = sp_q;
    case (state_q)
      S_IDLE: begin
        if (in_s.valid) begin
          res_d = '0;
          st_d  = ST_OK;
          case (mode_e'(in_s.mode))
            MODE_ALLOC: begin
              if (in_s.request_size == 32'd0) begin
                state_d = S_DONE;
              end else begin
                rnd_req.start = 1'b1;
                rnd_req.size  = {1'b0, in_s.request_size} + {32'd0, in_s.request_size[0]};
                rnd_req.gran  = (line_bytes_q == 16'd0) ? 16'd1 : line_bytes_q;
                state_d       = S_DIV;
              end
            end
            MODE_FREE: begin
              addr_d  = in_s.block_address;
              q_d     = NIL;
              p_d     = used_head_q;
              state_d = S_F_CHK;
            end
            MODE_QUERY: begin
              best_d  = '0;
              p_d     = free_head_q;
              state_d = vld(sp_q) ? S_Q_CHK : S_DONE;
            end
            default: begin
              // Reload: descriptor 0 becomes the whole pool.
              in_use_d    = '0;
              in_use_d[0] = 1'b1;
              ram_we      = 1'b1;
              ram_waddr   = '0;
              ram_wdata   = '{nxt: NIL, len: pool_length_q, start: pool_start_q};
              free_head_d = '0;
              sp_d        = '0;
              used_head_d = NIL;
              state_d     = S_DONE;
            end
          endcase
        end
      end
      S_DIV: begin
        if (rnd_rsp.done) begin
          if ((rnd_rsp.amt[33:32] != 2'd0) || !vld(sp_q)) begin
            st_d    = ST_NOFIT;
            state_d = S_DONE;
          end else begin
            amt_d   = rnd_rsp.amt[31:0];
            state_d = S_A_SP;
          end
        end
      end
      S_A_SP: begin
        ram_raddr = sp_q[IW-1:0];
        state_d   = S_A_SPD;
      end
      S_A_SPD: begin
        q_d     = sp_q;
        eq_d    = rd;
        p_d     = rd.nxt;
        state_d = S_A_CHK;
      end
      S_A_CHK: begin
        if (vld(p_q)) begin
          ram_raddr = p_q[IW-1:0];
          state_d   = S_A_EVAL;
        end else if (vld(free_head_q)) begin
          // Wrap around to the list head.
          q_d       = NIL;
          p_d       = free_head_q;
          ram_raddr = free_head_q[IW-1:0];
          state_d   = S_A_EVAL;
        end else begin
          st_d    = ST_NOFIT;
          state_d = S_DONE;
        end
      end
      S_A_EVAL: begin
        if (rd.len >= amt_q) begin
          ep_d = rd;
          if (rd.len == amt_q) begin
            link_d  = rd.nxt;
            state_d = S_A_WQ;
          end else begin
            gi_d    = '0;
            state_d = S_A_GRAB;
          end
        end else begin
          q_d  = p_q;
          eq_d = rd;
          p_d  = rd.nxt;
          if (p_q == sp_q) begin
            st_d    = ST_NOFIT;
            state_d = S_DONE;
          end else begin
            state_d = S_A_CHK;
          end
        end
      end
      S_A_GRAB: begin
        if (!in_use_q[gi_q]) begin
          in_use_d[gi_q] = 1'b1;
          s_d            = {1'b0, gi_q};
          state_d        = S_A_WS;
        end else if (gi_q == LAST) begin
          st_d    = ST_NODESC;
          state_d = S_DONE;
        end else begin
          gi_d = gi_q + 1'b1;
        end
      end
      S_A_WS: begin
        ram_we    = 1'b1;
        ram_waddr = s_q[IW-1:0];
        ram_wdata = '{nxt: ep_q.nxt, len: ep_q.len - amt_q, start: ep_q.start + amt_q};
        ep_d.len  = amt_q;
        link_d    = s_q;
        state_d   = S_A_WQ;
      end
      S_A_WQ: begin
        if (vld(q_q)) begin
          ram_we    = 1'b1;
          ram_waddr = q_q[IW-1:0];
          ram_wdata = '{nxt: link_q, len: eq_q.len, start: eq_q.start};
        end else begin
          free_head_d = link_q;
        end
        state_d = S_A_WP;
      end
      S_A_WP: begin
        ram_we      = 1'b1;
        ram_waddr   = p_q[IW-1:0];
        ram_wdata   = '{nxt: used_head_q, len: ep_q.len, start: ep_q.start};
        used_head_d = p_q;
        sp_d        = vld(q_q) ? q_q : free_head_q;
        res_d       = ep_q.start;
        st_d        = ST_OK;
        state_d     = S_DONE;
      end
      S_F_CHK: begin
        if (vld(p_q)) begin
          ram_raddr = p_q[IW-1:0];
          state_d   = S_F_EVAL;
        end else begin
          st_d    = ST_BADADDR;
          state_d = S_DONE;
        end
      end
      S_F_EVAL: begin
        if (rd.start == addr_q) begin
          // Unlink from the used list, then look for the insertion point.
          m_d  = p_q;
          em_d = rd;
          if (vld(q_q)) begin
            ram_we    = 1'b1;
            ram_waddr = q_q[IW-1:0];
            ram_wdata = '{nxt: rd.nxt, len: eq_q.len, start: eq_q.start};
          end else begin
            used_head_d = rd.nxt;
          end
          q_d     = NIL;
          p_d     = free_head_q;
          state_d = S_F_ICHK;
        end else begin
          q_d     = p_q;
          eq_d    = rd;
          p_d     = rd.nxt;
          state_d = S_F_CHK;
        end
      end
      S_F_ICHK: begin
        if (vld(p_q)) begin
          ram_raddr = p_q[IW-1:0];
          state_d   = S_F_IEVL;
        end else begin
          state_d = S_F_MN;
        end
      end
      S_F_IEVL: begin
        if (em_q.start <= rd.start) begin
          ep_d    = rd;
          state_d = S_F_MN;
        end else begin
          q_d     = p_q;
          eq_d    = rd;
          p_d     = rd.nxt;
          state_d = S_F_ICHK;
        end
      end
      S_F_MN: begin
        // Link in and merge with the following free block when they touch.
        em_n.nxt = p_q;
        if (vld(q_q)) begin
          eq_n.nxt = m_q;
        end else begin
          free_head_d = m_q;
        end
        sp1 = vld(sp_q) ? sp_q : m_q;
        if (vld(p_q) && (({1'b0, em_q.start} + {1'b0, em_q.len}) == {1'b0, ep_q.start})) begin
          em_n.len = em_q.len + ep_q.len;
          em_n.nxt = ep_q.nxt;
          if (p_q == sp1) begin
            sp1 = m_q;
          end
          in_use_d[p_q[IW-1:0]] = 1'b0;
        end
        em_d    = em_n;
        eq_d    = eq_n;
        sp_d    = sp1;
        state_d = S_F_MP;
      end
      S_F_MP: begin
        // Merge with the preceding free block when they touch.
        if (vld(q_q) && (({1'b0, eq_q.start} + {1'b0, eq_q.len}) == {1'b0, em_q.start})) begin
          eq_d.len = eq_q.len + em_q.len;
          eq_d.nxt = em_q.nxt;
          if (m_q == sp_q) begin
            sp_d = q_q;
          end
          in_use_d[m_q[IW-1:0]] = 1'b0;
        end
        state_d = S_F_WM;
      end
      S_F_WM: begin
        ram_we    = 1'b1;
        ram_waddr = m_q[IW-1:0];
        ram_wdata = em_q;
        state_d   = S_F_WQ;
      end
      S_F_WQ: begin
        if (vld(q_q)) begin
          ram_we    = 1'b1;
          ram_waddr = q_q[IW-1:0];
          ram_wdata = eq_q;
        end
        st_d    = ST_OK;
        state_d = S_DONE;
      end
      S_Q_CHK: begin
        if (vld(p_q)) begin
          ram_raddr = p_q[IW-1:0];
          state_d   = S_Q_EVAL;
        end else begin
          res_d   = (best_q <= QUERY_BIAS) ? 32'd0 : ((best_q - QUERY_BIAS) & QUERY_MASK);
          state_d = S_DONE;
        end
      end
      S_Q_EVAL: begin
        if (rd.len > best_q) begin
          best_d = rd.len;
        end
        p_d     = rd.nxt;
        state_d = S_Q_CHK;
      end
      S_DONE: begin
        if (load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      free_head_q   <= NIL;
      used_head_q   <= NIL;
      sp_q          <= NIL;
      in_use_q      <= '0;
      pool_start_q  <= '0;
      pool_length_q <= '0;
      line_bytes_q  <= LINE_BYTES_RST;
      out_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      free_head_q <= free_head_d;
      used_head_q <= used_head_d;
      sp_q        <= sp_d;
      in_use_q    <= in_use_d;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_POOL_START:  pool_start_q  <= cfg_data_i;
          CFG_POOL_LENGTH: pool_length_q <= cfg_data_i;
          CFG_LINE_BYTES:  line_bytes_q  <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_m.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_q    <= p_d;
    q_q    <= q_d;
    m_q    <= m_d;
    s_q    <= s_d;
    link_q <= link_d;
    ep_q   <= ep_d;
    eq_q   <= eq_d;
    em_q   <= em_d;
    gi_q   <= gi_d;
    amt_q  <= amt_d;
    addr_q <= addr_d;
    best_q <= best_d;
    res_q  <= res_d;
    st_q   <= st_d;
    if (load) begin
      out_res_q <= res_q;
      out_st_q  <= st_q;
    end
  end

  assign out_m.valid        = out_valid_q;
  assign out_m.result_value = out_res_q;
  assign out_m.status       = out_st_q;

`ifndef ASSERT_OFF
  // A non-empty free list always has a search pointer.
  a_sp_with_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld(free_head_q) |-> vld(sp_q)) else $error("search pointer lost with free blocks left");

  // A spare descriptor is owned by the time its entry is written.
  a_spare_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_A_WS) |-> in_use_q[s_q[IW-1:0]]) else $error("spare descriptor not owned");

  // Failed requests report a zero result.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_st_q != ST_OK)) |-> (out_res_q == 32'd0))
    else $error("nonzero result with error status");

  // The rounding unit only reports while an allocation waits for it.
  a_round_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rnd_rsp.done |-> (state_q == S_DIV)) else $error("rounding result outside allocation");
`endif

endmodule

// ----- test/nfba_checker.sv -----
// Scoreboard for the next-fit block allocator: predicts each result beat and compares it.
`timescale 1ns / 100ps
module nfba_checker import nfba_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  nfba_in_if          in_w,
  nfba_out_if         out_w,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam int NDESC = 256;
  localparam int NIL   = NDESC;
  localparam int WALK  = NDESC + 1;

  typedef struct {
    logic [31:0] value;
    status_e     status;
  } answer_t;

  logic [31:0] blk_start [NDESC];
  logic [31:0] blk_len   [NDESC];
  int          blk_next  [NDESC];
  bit          blk_busy  [NDESC];
  int          free_head, used_head, rover;
  logic [31:0] reg_start, reg_len;
  logic [15:0] reg_line;
  answer_t     answers_q[$];

  assign pending_o = answers_q.size();

  function automatic void link_free(int after, int v);
    if (after < NIL) blk_next[after] = v;
    else free_head = v;
  endfunction

  function automatic int take_spare();
    for (int i = 0; i < NDESC; i++) begin
      if (!blk_busy[i]) begin
        blk_busy[i] = 1'b1;
        return i;
      end
    end
    return NIL;
  endfunction

  function automatic status_e alloc_block(logic [63:0] amt, output logic [31:0] addr);
    int q, p, s;
    addr = '0;
    if (rover >= NIL || amt > 64'hFFFF_FFFF) return ST_NOFIT;
    q = rover;
    p = blk_next[q];
    for (int steps = 0; steps < WALK; steps++) begin
      if (p >= NIL) begin
        q = NIL;
        p = free_head;
        if (p >= NIL) return ST_NOFIT;
      end
      if ({32'd0, blk_len[p]} >= amt) begin
        if ({32'd0, blk_len[p]} == amt) begin
          link_free(q, blk_next[p]);
        end else begin
          s = take_spare();
          if (s >= NIL) return ST_NODESC;
          blk_len[s]   = blk_len[p] - amt[31:0];
          blk_start[s] = blk_start[p] + amt[31:0];
          blk_next[s]  = blk_next[p];
          blk_len[p]   = amt[31:0];
          link_free(q, s);
        end
        blk_next[p] = used_head;
        used_head = p;
        rover = (q < NIL) ? q : free_head;
        addr = blk_start[p];
        return ST_OK;
      end
      q = p;
      p = blk_next[p];
      if (q == rover) break;
    end
    return ST_NOFIT;
  endfunction

  function automatic void insert_free(int m);
    int p, q, steps;
    p = free_head;
    q = NIL;
    steps = 0;
    while (p < NIL && steps < WALK) begin
      if (blk_start[m] <= blk_start[p]) break;
      q = p;
      p = blk_next[p];
      steps++;
    end
    if (p >= NIL) p = NIL;
    blk_next[m] = p;
    link_free(q, m);
    if (rover >= NIL) rover = m;
    // Merge with the following block, then with the preceding one; no wrap.
    if (p < NIL && {32'd0, blk_start[m]} + blk_len[m] == {32'd0, blk_start[p]}) begin
      blk_len[m] += blk_len[p];
      blk_next[m] = blk_next[p];
      if (p == rover) rover = m;
      blk_busy[p] = 1'b0;
    end
    if (q < NIL && {32'd0, blk_start[q]} + blk_len[q] == {32'd0, blk_start[m]}) begin
      blk_len[q] += blk_len[m];
      blk_next[q] = blk_next[m];
      if (m == rover) rover = q;
      blk_busy[m] = 1'b0;
    end
  endfunction

  function automatic status_e release_block(logic [31:0] addr);
    int prev, p, steps;
    prev = NIL;
    p = used_head;
    steps = 0;
    while (p < NIL && steps < WALK) begin
      if (blk_start[p] == addr) break;
      prev = p;
      p = blk_next[p];
      steps++;
    end
    if (p >= NIL || blk_start[p] != addr) return ST_BADADDR;
    if (prev < NIL) blk_next[prev] = blk_next[p];
    else used_head = blk_next[p];
    insert_free(p);
    return ST_OK;
  endfunction

  function automatic logic [31:0] largest_free();
    int p;
    logic [31:0] best;
    best = '0;
    if (rover >= NIL) return '0;
    p = free_head;
    for (int steps = 0; steps < WALK && p < NIL; steps++) begin
      if (blk_len[p] > best) best = blk_len[p];
      p = blk_next[p];
    end
    if (best <= QUERY_BIAS) return '0;
    return (best - QUERY_BIAS) & QUERY_MASK;
  endfunction

  function automatic answer_t predict(mode_e m, logic [31:0] size, logic [31:0] addr);
    answer_t a;
    logic [63:0] amt, gran;
    a.value = '0;
    a.status = ST_OK;
    case (m)
      MODE_ALLOC: begin
        if (size != 0) begin
          gran = (reg_line != 0) ? {48'd0, reg_line} : 64'd1;
          amt = {32'd0, size} + size[0];
          amt = ((amt + gran - 1) / gran) * gran;
          a.status = alloc_block(amt, a.value);
          if (a.status != ST_OK) a.value = '0;
        end
      end
      MODE_FREE: a.status = release_block(addr);
      MODE_QUERY: a.value = largest_free();
      default: begin
        for (int i = 0; i < NDESC; i++) blk_busy[i] = 1'b0;
        blk_start[0] = reg_start;
        blk_len[0] = reg_len;
        blk_next[0] = NIL;
        blk_busy[0] = 1'b1;
        free_head = 0;
        rover = 0;
        used_head = NIL;
      end
    endcase
    return a;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t got, want;
    if (!rst_ni) begin
      reg_start = '0;
      reg_len = '0;
      reg_line = LINE_BYTES_RST;
      for (int i = 0; i < NDESC; i++) begin
        blk_start[i] = '0;
        blk_len[i] = '0;
        blk_next[i] = 0;
        blk_busy[i] = 1'b0;
      end
      free_head = NIL;
      used_head = NIL;
      rover = NIL;
      fail_count_o = 0;
      answers_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_POOL_START:  reg_start = cfg_data_i;
          CFG_POOL_LENGTH: reg_len = cfg_data_i;
          CFG_LINE_BYTES:  reg_line = cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (in_w.valid && in_w.ready)
        answers_q.push_back(predict(mode_e'(in_w.mode), in_w.request_size,
                                    in_w.block_address));
      if (out_w.valid && out_w.ready) begin
        if (answers_q.size() == 0) begin
          $error("unexpected result beat: result_value %h status %0d",
                 out_w.result_value, out_w.status);
          fail_count_o++;
        end else begin
          want = answers_q.pop_front();
          got.value = out_w.result_value;
          got.status = status_e'(out_w.status);
          if (got.value !== want.value) begin
            $error("result_value: expected %h, actual %h", want.value, got.value);
            fail_count_o++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_w.status);
            fail_count_o++;
          end
        end
      end
    end
  end

endmodule

// ----- test/tb_top.sv -----
// Stimulus and verdict for the next-fit block allocator regression.
`timescale 1ns / 100ps
module tb_top;
  import nfba_pkg::*;

  // The watchdog limit covers the slowest beat: a free that walks both full lists,
  // or an allocation that rounds, walks and hunts for a spare, plus a long stall of
  // the receiver at its heaviest idling.
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 1200;

  typedef struct {
    mode_e       mode;
    logic [31:0] size;
  } sent_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  int          fail_count, pending;
  int          tx_idle, rx_idle;
  int          quiet_cycles;
  sent_t       sent_q[$];
  logic [31:0] live_q[$];

  nfba_in_if  req_if ();
  nfba_out_if rsp_if ();

  always #5 clk_i = ~clk_i;

  next_fit_block_allocator_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_s       (req_if),
    .out_m      (rsp_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  nfba_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_w         (req_if),
    .out_w        (rsp_if),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    req_if.valid = 1'b0;
    req_if.mode = MODE_QUERY;
    req_if.request_size = '0;
    req_if.block_address = '0;
    rsp_if.ready = 1'b0;
  end

  // The receiver stalls at random with the rate of the current phase.
  always @(posedge clk_i) begin
    rsp_if.ready <= ($urandom_range(99) >= rx_idle);
  end

  // Granted allocations are remembered so that most frees name a live block.
  always @(posedge clk_i) begin
    sent_t s;
    if (rsp_if.valid && rsp_if.ready && sent_q.size() != 0) begin
      s = sent_q.pop_front();
      if (s.mode == MODE_ALLOC && s.size != 0 && rsp_if.status == ST_OK)
        live_q.push_back(rsp_if.result_value);
    end
  end

  // A stuck handshake on either channel ends the run.
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("next_fit_block_allocator_unit regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one request beat, idling first at the sender's rate, and holds it until taken.
  task automatic send_beat(mode_e m, logic [31:0] size, logic [31:0] addr);
    sent_t s;
    if ($urandom_range(99) < tx_idle) begin
      req_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle);
    end
    req_if.valid <= 1'b1;
    req_if.mode <= m;
    req_if.request_size <= size;
    req_if.block_address <= addr;
    do @(posedge clk_i); while (!req_if.ready);
    s.mode = m;
    s.size = size;
    sent_q.push_back(s);
  endtask

  // Lets every expected result arrive; the block is idle afterwards.
  task automatic drain();
    @(posedge clk_i);
    req_if.valid <= 1'b0;
    while (pending != 0 || sent_q.size() != 0) @(posedge clk_i);
  endtask

  // Writes all three registers on an idle block and reloads the pool from them.
  task automatic set_pool(logic [31:0] start, logic [31:0] len, logic [15:0] line);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_POOL_START;
    cfg_data_i <= start;
    @(posedge clk_i);
    cfg_idx_i <= CFG_POOL_LENGTH;
    cfg_data_i <= len;
    @(posedge clk_i);
    cfg_idx_i <= CFG_LINE_BYTES;
    cfg_data_i <= {16'd0, line};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    live_q.delete();
    send_beat(MODE_RELOAD, $urandom, $urandom);
  endtask

  // One random request: mostly allocations of modest size and frees of live blocks.
  task automatic random_beat();
    int pick, idx;
    logic [31:0] size, addr;
    pick = $urandom_range(99);
    if (pick < 45) begin
      case ($urandom_range(9))
        0: size = $urandom;
        1: size = 32'd0;
        2: size = $urandom_range(4096);
        default: size = $urandom_range(1, 300);
      endcase
      send_beat(MODE_ALLOC, size, $urandom);
    end else if (pick < 82) begin
      if (live_q.size() != 0 && $urandom_range(9) != 0) begin
        idx = $urandom_range(live_q.size() - 1);
        addr = live_q[idx];
        live_q.delete(idx);
      end else begin
        addr = $urandom;
      end
      send_beat(MODE_FREE, $urandom, addr);
    end else if (pick < 97) begin
      send_beat(MODE_QUERY, $urandom, $urandom);
    end else begin
      live_q.delete();
      send_beat(MODE_RELOAD, $urandom, $urandom);
    end
  endtask

  initial begin
    tx_idle = 0;
    rx_idle = 0;
    quiet_cycles = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Before any reload there is no free block at all.
    send_beat(MODE_ALLOC, 32'd8, 32'd0);
    send_beat(MODE_QUERY, 32'd0, 32'd0);
    send_beat(MODE_FREE, 32'd0, 32'd0);

    set_pool(32'h0000_1000, 32'h0000_1000, 16'd16);
    send_beat(MODE_ALLOC, 32'd0, 32'hFFFF_FFFF);       // zero size
    send_beat(MODE_ALLOC, 32'd1, 32'd0);               // odd size, rounds to a line
    send_beat(MODE_ALLOC, 32'h0000_0800, 32'd0);
    send_beat(MODE_ALLOC, 32'h0000_1000, 32'd0);       // nothing large enough
    send_beat(MODE_ALLOC, 32'hFFFF_FFFF, 32'd0);       // rounds past 32 bits
    send_beat(MODE_QUERY, 32'd0, 32'd0);
    send_beat(MODE_FREE, 32'd0, 32'h0000_1234);        // unknown address
    send_beat(MODE_FREE, 32'd0, 32'h0000_1000);
    send_beat(MODE_FREE, 32'd0, 32'h0000_1010);        // merges both neighbors
    send_beat(MODE_ALLOC, 32'h0000_07F0, 32'd0);       // splits the merged pool
    send_beat(MODE_QUERY, 32'd0, 32'd0);

    // A granule of zero counts as one, so sizes are only made even; the pool straddles the top of memory.
    set_pool(32'hFFFF_FF00, 32'h0000_0400, 16'd0);
    send_beat(MODE_ALLOC, 32'h0000_0100, 32'd0);
    send_beat(MODE_ALLOC, 32'h0000_0102, 32'd0);
    send_beat(MODE_FREE, 32'd0, 32'h0000_0000);
    send_beat(MODE_FREE, 32'd0, 32'hFFFF_FF00);
    send_beat(MODE_QUERY, 32'd0, 32'd0);

    // Widest granule and the largest pool.
    set_pool(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    send_beat(MODE_ALLOC, 32'd3, 32'd0);
    send_beat(MODE_ALLOC, 32'hFFFF_FFFF, 32'd0);
    send_beat(MODE_QUERY, 32'd0, 32'd0);

    // Random part: sender idles lightly while the receiver stalls heavily.
    tx_idle = 7;
    rx_idle = 82;
    set_pool(32'h0001_0000, 32'h0000_4000, 16'd16);
    repeat (70) random_beat();

    // The other way round, with a random pool and granule.
    tx_idle = 82;
    rx_idle = 7;
    set_pool($urandom, $urandom_range(32'h0001_0000, 32'h0000_0100),
             16'($urandom_range(1, 64)));
    repeat (70) random_beat();

    // No idling. A long run of tiny allocations uses up every descriptor.
    tx_idle = 0;
    rx_idle = 0;
    set_pool(32'h0010_0000, 32'h0010_0000, 16'd2);
    repeat (270) send_beat(MODE_ALLOC, $urandom_range(1, 6), 32'd0);
    send_beat(MODE_QUERY, 32'd0, 32'd0);
    repeat (20) random_beat();
    set_pool($urandom, $urandom, 16'($urandom));
    repeat (40) random_beat();

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("next_fit_block_allocator_unit regression: pass");
    end else begin
      $display("next_fit_block_allocator_unit regression: fail");
    end
    $finish;
  end

endmodule
